[sv/sbc_pkg.sv]
// package for the sphere/box collision response pipeline
// widths, item and sideband types, register codes; no dependencies
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int RAD_W      = 25;
  localparam int REST_W     = 17;
  localparam int REST_FRAC  = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = RAD_W;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int MID_W   = DIFF_W + 1;
  localparam int MAG_W   = RAD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int D2_W    = SQ_W + 2;
  localparam int ROOT_W  = D2_W / 2;
  localparam int NMAG_W  = FRAC_BITS + 1;
  localparam int QUO_BITS = FRAC_BITS + 1;
  localparam int DIVD_W  = ROOT_W + FRAC_BITS;
  localparam int SAT_W   = COORD_W + 8;
  localparam int VN_W    = COORD_W + 3;
  localparam int VNM_W   = VN_W - 1;
  localparam int KM_W    = COORD_W + 4;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(16384);
  localparam logic [REST_W-1:0] REST_RESET   = REST_W'(7864);
  localparam logic [NMAG_W-1:0] NORM_ONE     = NMAG_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 'd0,
    REG_REST   = 'd1
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t [2:0] pos;
    coord_t [2:0] vel;
    coord_t [2:0] bmin;
    coord_t [2:0] bmax;
  } in_item_t;

  typedef struct packed {
    coord_t [2:0] pos;
    coord_t [2:0] vel;
    logic         contact;
  } out_item_t;

  // what travels alongside the root and divide stages
  typedef struct packed {
    coord_t [2:0]                 pos;
    coord_t [2:0]                 vel;
    coord_t [2:0]                 cl;
    logic   [2:0]                 neg;
    logic   [2:0][MAG_W-1:0]      mag;
    logic   [2:0][NMAG_W-1:0]     in_nmag;
    logic   [2:0]                 in_nneg;
    logic                         hit;
    logic                         in_box;
  } side_t;

endpackage

[sv/sbc_req_if.sv]
// input item channel, valid/ready with the sphere and box fields
// depends on sbc_pkg
`timescale 1ns / 1ps

interface sbc_req_if;
  import sbc_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pos_x, pos_y, pos_z;
  coord_t vel_x, vel_y, vel_z;
  coord_t box_min_x, box_min_y, box_min_z;
  coord_t box_max_x, box_max_y, box_max_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

[sv/sbc_rsp_if.sv]
// result channel, valid/ready with resolved position, velocity and contact
// depends on sbc_pkg
`timescale 1ns / 1ps

interface sbc_rsp_if;
  import sbc_pkg::*;

  logic   valid;
  logic   ready;
  coord_t new_pos_x, new_pos_y, new_pos_z;
  coord_t new_vel_x, new_vel_y, new_vel_z;
  logic   contact;

  modport source (
    output valid, new_pos_x, new_pos_y, new_pos_z,
           new_vel_x, new_vel_y, new_vel_z, contact,
    input  ready
  );
  modport sink (
    input  valid, new_pos_x, new_pos_y, new_pos_z,
           new_vel_x, new_vel_y, new_vel_z, contact,
    output ready
  );
endinterface

[sv/sbc_cfg_if.sv]
// register write channel, valid/ready with index and data
// depends on sbc_pkg
`timescale 1ns / 1ps

interface sbc_cfg_if;
  import sbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/sbc_front.sv]
// front stages: clamp to box, offsets, squared distance, overlap test and
// the nearest-face normal for a centre inside the box; depends on sbc_pkg
`timescale 1ns / 1ps

module sbc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  sbc_pkg::in_item_t        in_item,
  input  logic [sbc_pkg::RAD_W-1:0] radius,
  output logic                     out_valid,
  output sbc_pkg::side_t           out_side,
  output logic [sbc_pkg::D2_W-1:0] out_d2
);
  import sbc_pkg::*;

  // stage 1
  logic                      v1;
  coord_t [2:0]              pos1, vel1, cl1;
  logic signed [DIFF_W-1:0]  a1 [3];
  logic signed [DIFF_W-1:0]  b1 [3];
  logic [2:0]                lt1;
  // stage 2
  logic                      v2;
  coord_t [2:0]              pos2, vel2, cl2;
  logic [2:0]                neg2;
  logic [2:0][MAG_W-1:0]     mag2;
  logic                      near2;
  logic signed [DIFF_W-1:0]  fd2 [3];
  logic [2:0]                lt2;
  // stage 3
  logic                      v3;
  coord_t [2:0]              pos3, vel3, cl3;
  logic [2:0]                neg3;
  logic [2:0][MAG_W-1:0]     mag3;
  logic                      near3;
  logic [SQ_W-1:0]           sq3 [3];
  logic [SQ_W-1:0]           rr3;
  logic [2:0][NMAG_W-1:0]    nmag3;
  logic [2:0]                nneg3;

  logic signed [DIFF_W-1:0]  dl_c [3];
  logic [DIFF_W-1:0]         mag_c [3];
  logic [1:0]                ax_c;
  logic [D2_W-1:0]           d2_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dl_c[i]  = DIFF_W'(pos1[i]) - DIFF_W'(cl1[i]);
      mag_c[i] = dl_c[i][DIFF_W-1] ? DIFF_W'(-dl_c[i]) : DIFF_W'(dl_c[i]);
    end
    if (fd2[0] <= fd2[1] && fd2[0] <= fd2[2]) begin
      ax_c = 2'd0;
    end else if (fd2[1] <= fd2[2]) begin
      ax_c = 2'd1;
    end else begin
      ax_c = 2'd2;
    end
    d2_c = D2_W'(sq3[0]) + D2_W'(sq3[1]) + D2_W'(sq3[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // clamp and face distances
      for (int i = 0; i < 3; i++) begin
        pos1[i] <= in_item.pos[i];
        vel1[i] <= in_item.vel[i];
        if ($signed(in_item.pos[i]) < $signed(in_item.bmin[i])) begin
          cl1[i] <= in_item.bmin[i];
        end else if ($signed(in_item.pos[i]) > $signed(in_item.bmax[i])) begin
          cl1[i] <= in_item.bmax[i];
        end else begin
          cl1[i] <= in_item.pos[i];
        end
        a1[i]  <= DIFF_W'($signed(in_item.pos[i])) - DIFF_W'($signed(in_item.bmin[i]));
        b1[i]  <= DIFF_W'($signed(in_item.bmax[i])) - DIFF_W'($signed(in_item.pos[i]));
        lt1[i] <= (MID_W'($signed(in_item.pos[i])) <<< 1) <
                  (MID_W'($signed(in_item.bmin[i])) + MID_W'($signed(in_item.bmax[i])));
      end
      // offset magnitudes against the radius
      pos2 <= pos1;
      vel2 <= vel1;
      cl2  <= cl1;
      lt2  <= lt1;
      for (int i = 0; i < 3; i++) begin
        neg2[i] <= dl_c[i][DIFF_W-1];
        mag2[i] <= mag_c[i][MAG_W-1:0];
        fd2[i]  <= (a1[i] < b1[i]) ? a1[i] : b1[i];
      end
      near2 <= (mag_c[0] < DIFF_W'(radius)) && (mag_c[1] < DIFF_W'(radius)) &&
               (mag_c[2] < DIFF_W'(radius));
      // squares and the inside normal
      pos3  <= pos2;
      vel3  <= vel2;
      cl3   <= cl2;
      neg3  <= neg2;
      mag3  <= mag2;
      near3 <= near2;
      rr3   <= radius * radius;
      for (int i = 0; i < 3; i++) begin
        sq3[i]   <= mag2[i] * mag2[i];
        nmag3[i] <= (ax_c == 2'(i)) ? NORM_ONE : '0;
        nneg3[i] <= (ax_c == 2'(i)) && lt2[i];
      end
      // distance sum and final overlap decision
      out_side.pos     <= pos3;
      out_side.vel     <= vel3;
      out_side.cl      <= cl3;
      out_side.neg     <= neg3;
      out_side.mag     <= mag3;
      out_side.in_nmag <= nmag3;
      out_side.in_nneg <= nneg3;
      out_side.hit     <= near3 && (d2_c < D2_W'(rr3));
      out_side.in_box  <= (d2_c == '0);
      out_d2           <= d2_c;
    end
  end

endmodule

[sv/sbc_sqrt.sv]
// integer square root of the squared distance, one result bit per stage
// depends on sbc_pkg
`timescale 1ns / 1ps

module sbc_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  sbc_pkg::side_t             in_side,
  input  logic [sbc_pkg::D2_W-1:0]   in_d2,
  output logic                       out_valid,
  output sbc_pkg::side_t             out_side,
  output logic [sbc_pkg::ROOT_W-1:0] out_root
);
  import sbc_pkg::*;

  logic            v_q    [ROOT_W];
  side_t           side_q [ROOT_W];
  logic [D2_W-1:0] x_q    [ROOT_W];
  logic [D2_W-1:0] res_q  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_st
    localparam int SH = 2 * (ROOT_W - 1 - j);
    logic            vp;
    side_t           sp;
    logic [D2_W-1:0] xp, rp, trial;

    if (j == 0) begin : g_first
      assign vp = in_valid;
      assign sp = in_side;
      assign xp = in_d2;
      assign rp = '0;
    end else begin : g_next
      assign vp = v_q[j-1];
      assign sp = side_q[j-1];
      assign xp = x_q[j-1];
      assign rp = res_q[j-1];
    end

    assign trial = rp + (D2_W'(1) << SH);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (adv) begin
        v_q[j] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_q[j] <= sp;
        if (xp >= trial) begin
          x_q[j]   <= xp - trial;
          res_q[j] <= (rp >> 1) + (D2_W'(1) << SH);
        end else begin
          x_q[j]   <= xp;
          res_q[j] <= rp >> 1;
        end
      end
    end
  end

  assign out_valid = v_q[ROOT_W-1];
  assign out_side  = side_q[ROOT_W-1];
  assign out_root  = res_q[ROOT_W-1][ROOT_W-1:0];

endmodule

[sv/sbc_div.sv]
// normal components: offset magnitude scaled by 2^frac over the root,
// restoring divide, one quotient bit per stage on three lanes; depends on sbc_pkg
`timescale 1ns / 1ps

module sbc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  sbc_pkg::side_t                    in_side,
  input  logic [sbc_pkg::ROOT_W-1:0]        in_root,
  output logic                              out_valid,
  output sbc_pkg::side_t                    out_side,
  output logic [2:0][sbc_pkg::NMAG_W-1:0]   out_quo
);
  import sbc_pkg::*;

  logic              v_q    [QUO_BITS];
  side_t             side_q [QUO_BITS];
  logic [ROOT_W-1:0] d_q    [QUO_BITS];
  logic [DIVD_W-1:0] rem_q  [QUO_BITS][3];
  logic [NMAG_W-1:0] quo_q  [QUO_BITS][3];

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_st
    localparam int K = FRAC_BITS - j;
    logic              vp;
    side_t             sp;
    logic [ROOT_W-1:0] dp;
    logic [DIVD_W-1:0] dsh;

    if (j == 0) begin : g_first
      assign vp = in_valid;
      assign sp = in_side;
      assign dp = in_root;
    end else begin : g_next
      assign vp = v_q[j-1];
      assign sp = side_q[j-1];
      assign dp = d_q[j-1];
    end

    assign dsh = DIVD_W'(dp) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (adv) begin
        v_q[j] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_q[j] <= sp;
        d_q[j]    <= dp;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DIVD_W-1:0] rp;
      logic [NMAG_W-1:0] qp;

      if (j == 0) begin : g_first
        assign rp = DIVD_W'(in_side.mag[l]) << FRAC_BITS;
        assign qp = '0;
      end else begin : g_next
        assign rp = rem_q[j-1][l];
        assign qp = quo_q[j-1][l];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          if (rp >= dsh) begin
            rem_q[j][l] <= rp - dsh;
            quo_q[j][l] <= qp | (NMAG_W'(1) << K);
          end else begin
            rem_q[j][l] <= rp;
            quo_q[j][l] <= qp;
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_quo[l] = quo_q[QUO_BITS-1][l];
    end
  end

  assign out_valid = v_q[QUO_BITS-1];
  assign out_side  = side_q[QUO_BITS-1];

endmodule

[sv/sbc_resp.sv]
// response stages: normal select, pushed-out position, normal speed,
// restitution and velocity reflection with saturation; depends on sbc_pkg
`timescale 1ns / 1ps

module sbc_resp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  sbc_pkg::side_t                     in_side,
  input  logic [2:0][sbc_pkg::NMAG_W-1:0]    in_quo,
  input  logic [sbc_pkg::RAD_W-1:0]          radius,
  input  logic [sbc_pkg::REST_W-1:0]         rest,
  output logic                               out_valid,
  output sbc_pkg::out_item_t                 out_item
);
  import sbc_pkg::*;

  function automatic coord_t sat_c(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-COORD_W:0] top;
    top = v[SAT_W-1:COORD_W-1];
    if (&top || ~|top) begin
      return v[COORD_W-1:0];
    end
    return v[SAT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  function automatic logic signed [SAT_W-1:0] sgn(input logic [SAT_W-2:0] m,
                                                  input logic neg);
    logic signed [SAT_W-1:0] s;
    s = $signed({1'b0, m});
    return neg ? -s : s;
  endfunction

  logic                           v1, v2, v3, v4, v5, v6;
  side_t                          s1, s2, s3, s4, s5, s6;
  logic [2:0][NMAG_W-1:0]         nm1, nm2, nm3, nm4, nm5, nm6;
  logic [2:0]                     nn1, nn2, nn3, nn4, nn5, nn6;
  logic [RAD_W+NMAG_W-1:0]        pr2 [3];
  logic [COORD_W+NMAG_W-1:0]      pv2 [3];
  logic [2:0]                     ps2;
  coord_t [2:0]                   np3, np4, np5, np6;
  logic signed [VN_W-1:0]         vn3, vn4;
  logic [VNM_W+REST_W-1:0]        pk4;
  logic                           vneg4, appr5, appr6;
  logic [KM_W-1:0]                km5;
  logic                           kneg5;
  logic [KM_W+NMAG_W-1:0]         pkn6 [3];
  logic [2:0]                     ks6;

  logic signed [SAT_W-1:0]        vn_c, kk_c;
  logic [COORD_W-1:0]             vm_c [3];

  always_comb begin
    vn_c = '0;
    for (int i = 0; i < 3; i++) begin
      vn_c = vn_c + sgn((SAT_W-1)'(pv2[i] >> FRAC_BITS), ps2[i]);
      vm_c[i] = s1.vel[i][COORD_W-1] ? COORD_W'(-s1.vel[i]) : COORD_W'(s1.vel[i]);
    end
    kk_c = SAT_W'(vn4) + sgn((SAT_W-1)'(pk4 >> REST_FRAC), vneg4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // normal: face axis when inside, quotient otherwise
      s1 <= in_side;
      for (int i = 0; i < 3; i++) begin
        if (in_side.in_box) begin
          nm1[i] <= in_side.in_nmag[i];
          nn1[i] <= in_side.in_nneg[i];
        end else begin
          nm1[i] <= (in_quo[i] > NORM_ONE) ? NORM_ONE : in_quo[i];
          nn1[i] <= in_side.neg[i];
        end
      end
      // products against radius and velocity
      s2  <= s1;
      nm2 <= nm1;
      nn2 <= nn1;
      for (int i = 0; i < 3; i++) begin
        pr2[i] <= nm1[i] * radius;
        pv2[i] <= vm_c[i] * nm1[i];
        ps2[i] <= s1.vel[i][COORD_W-1] ^ nn1[i];
      end
      // new position and speed along the normal
      s3  <= s2;
      nm3 <= nm2;
      nn3 <= nn2;
      vn3 <= VN_W'(vn_c);
      for (int i = 0; i < 3; i++) begin
        np3[i] <= sat_c(SAT_W'($signed(s2.cl[i])) +
                        sgn((SAT_W-1)'(pr2[i] >> FRAC_BITS), nn2[i]));
      end
      // restitution product
      s4    <= s3;
      nm4   <= nm3;
      nn4   <= nn3;
      np4   <= np3;
      vn4   <= vn3;
      vneg4 <= vn3[VN_W-1];
      pk4   <= (vn3[VN_W-1] ? VNM_W'(-vn3) : VNM_W'(vn3)) * rest;
      // impulse scale
      s5    <= s4;
      nm5   <= nm4;
      nn5   <= nn4;
      np5   <= np4;
      appr5 <= vneg4;
      kneg5 <= kk_c[SAT_W-1];
      km5   <= kk_c[SAT_W-1] ? KM_W'(-kk_c) : KM_W'(kk_c);
      // impulse along each axis
      s6    <= s5;
      nm6   <= nm5;
      nn6   <= nn5;
      np6   <= np5;
      appr6 <= appr5;
      for (int i = 0; i < 3; i++) begin
        pkn6[i] <= km5 * nm5[i];
        ks6[i]  <= kneg5 ^ nn5[i];
      end
      // output register
      out_item.contact <= s6.hit;
      for (int i = 0; i < 3; i++) begin
        if (!s6.hit) begin
          out_item.pos[i] <= s6.pos[i];
          out_item.vel[i] <= s6.vel[i];
        end else begin
          out_item.pos[i] <= np6[i];
          if (appr6) begin
            out_item.vel[i] <= sat_c(SAT_W'($signed(s6.vel[i])) -
                                     sgn((SAT_W-1)'(pkn6[i] >> FRAC_BITS), ks6[i]));
          end else begin
            out_item.vel[i] <= s6.vel[i];
          end
        end
      end
    end
  end

  // normal magnitudes past the impulse stage are only carried
  logic unused_nm;
  assign unused_nm = ^{nm6, nn6, s3.mag, s4.mag};

endmodule

[sv/sphere_box_collision_response.sv]
// Sphere/box collision response. One test enters per clock unless the output is held, and
// it passes 4 front stages (clamp, offsets, squares, overlap), 26 square-root stages that
// each settle one bit of the distance, 17 divide stages that each settle one bit of the
// normal, and 7 response stages ending in the output register. When the output is held
// the whole pipeline holds with it, so a new item is taken in any cycle the output is
// empty or being transferred. Register writes may be issued only when no item is in flight.
// top level; depends on sbc_pkg, the channel interfaces, sbc_front, sbc_sqrt, sbc_div, sbc_resp
`timescale 1ns / 1ps

module sphere_box_collision_response (
  input  logic       clk,
  input  logic       rst,
  sbc_req_if.sink    req,
  sbc_rsp_if.source  rsp,
  sbc_cfg_if.sink    cfg
);
  import sbc_pkg::*;

  logic [RAD_W-1:0]  radius;
  logic [REST_W-1:0] rest;
  logic              adv;
  in_item_t          item;
  out_item_t         res_item;

  logic              f_valid, s_valid, d_valid;
  side_t             f_side, s_side, d_side;
  logic [D2_W-1:0]   f_d2;
  logic [ROOT_W-1:0] s_root;
  logic [2:0][NMAG_W-1:0] d_quo;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      rest   <= REST_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_RADIUS: radius <= cfg.data[RAD_W-1:0];
        REG_REST:   rest   <= cfg.data[REST_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register can take a new value
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  assign item.pos[0]  = req.pos_x;
  assign item.pos[1]  = req.pos_y;
  assign item.pos[2]  = req.pos_z;
  assign item.vel[0]  = req.vel_x;
  assign item.vel[1]  = req.vel_y;
  assign item.vel[2]  = req.vel_z;
  assign item.bmin[0] = req.box_min_x;
  assign item.bmin[1] = req.box_min_y;
  assign item.bmin[2] = req.box_min_z;
  assign item.bmax[0] = req.box_max_x;
  assign item.bmax[1] = req.box_max_y;
  assign item.bmax[2] = req.box_max_z;

  sbc_front u_front (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(req.valid), .in_item(item), .radius(radius),
    .out_valid(f_valid), .out_side(f_side), .out_d2(f_d2)
  );

  sbc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(f_valid), .in_side(f_side), .in_d2(f_d2),
    .out_valid(s_valid), .out_side(s_side), .out_root(s_root)
  );

  sbc_div u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(s_valid), .in_side(s_side), .in_root(s_root),
    .out_valid(d_valid), .out_side(d_side), .out_quo(d_quo)
  );

  sbc_resp u_resp (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(d_valid), .in_side(d_side), .in_quo(d_quo),
    .radius(radius), .rest(rest),
    .out_valid(rsp.valid), .out_item(res_item)
  );

  assign rsp.new_pos_x = res_item.pos[0];
  assign rsp.new_pos_y = res_item.pos[1];
  assign rsp.new_pos_z = res_item.pos[2];
  assign rsp.new_vel_x = res_item.vel[0];
  assign rsp.new_vel_y = res_item.vel[1];
  assign rsp.new_vel_z = res_item.vel[2];
  assign rsp.contact   = res_item.contact;

endmodule

[sv/sbc_checker.sv]
// port-level checks on the collision response block, bound to the top level
// depends on sbc_pkg and sphere_box_collision_response
`timescale 1ns / 1ps

module sbc_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input sbc_pkg::coord_t new_pos_x,
  input sbc_pkg::coord_t new_pos_y,
  input sbc_pkg::coord_t new_pos_z,
  input sbc_pkg::coord_t new_vel_x,
  input sbc_pkg::coord_t new_vel_y,
  input sbc_pkg::coord_t new_vel_z,
  input logic            contact
);
  import sbc_pkg::*;

  logic [6*COORD_W:0] payload;
  logic               unused_req;

  assign payload = {new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
                    contact};
  assign unused_req = req_valid;

  // no result may survive a reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // an empty or draining output must never block the input side
  a_take: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || rsp_ready) |-> req_ready)
    else $error("input stalled while output free");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(payload))
    else $error("result changed while stalled");

endmodule

bind sphere_box_collision_response sbc_checker u_sbc_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .new_pos_x(rsp.new_pos_x), .new_pos_y(rsp.new_pos_y), .new_pos_z(rsp.new_pos_z),
  .new_vel_x(rsp.new_vel_x), .new_vel_y(rsp.new_vel_y), .new_vel_z(rsp.new_vel_z),
  .contact(rsp.contact)
);

[verif/tb_sphere_box_collision_response.sv]
// testbench for the sphere/box collision response pipeline: directed and random tests
// with a bit-exact predictor and an in-order result check; depends on sbc_pkg and the
// request, response and register channel interfaces
`timescale 1ns / 1ps

module tb_sphere_box_collision_response;
  import sbc_pkg::*;

  logic clk;
  logic rst;

  sbc_req_if req ();
  sbc_rsp_if rsp ();
  sbc_cfg_if cfg ();

  sphere_box_collision_response dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  typedef struct {
    longint pos [3];
    longint vel [3];
    longint bmin [3];
    longint bmax [3];
  } test_t;

  typedef struct {
    logic [COORD_W-1:0] pos [3];
    logic [COORD_W-1:0] vel [3];
    logic               contact;
  } resolved_t;

  resolved_t   pending_q [$];
  longint      radius;
  longint      restitution;
  int          errors;
  int          n_items;
  int          n_contacts;
  int          n_results;
  bit          stim_done;
  bit          long_stalls;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic longint sat_coord(longint v);
    longint hi;
    hi = (64'sd1 <<< (COORD_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  // truncating fixed-point product, magnitudes split so nothing overflows
  function automatic longint fx_mul(longint a, longint b, int sh);
    longint unsigned ua, ub, r;
    ua = abs_l(a);
    ub = abs_l(b);
    r = (ua >> sh) * ub + (((ua & ((64'd1 << sh) - 1)) * ub) >> sh);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic resolved_t resolve(test_t t);
    resolved_t      o;
    longint         cl [3];
    longint         dl [3];
    longint         nrm [3];
    longint         fd [3];
    longint         one, d, q, vn, k, a, b;
    longint unsigned d2;
    bit             hit;
    int             ax;
    one = 64'sd1 <<< FRAC_BITS;
    hit = 1'b1;
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      cl[i] = t.pos[i] < t.bmin[i] ? t.bmin[i] : (t.pos[i] > t.bmax[i] ? t.bmax[i] : t.pos[i]);
      dl[i] = t.pos[i] - cl[i];
      if (abs_l(dl[i]) >= radius) hit = 1'b0;
    end
    if (hit) begin
      for (int i = 0; i < 3; i++) d2 += abs_l(dl[i]) * abs_l(dl[i]);
      if (d2 >= longint'(radius) * radius) hit = 1'b0;
    end
    if (!hit) begin
      for (int i = 0; i < 3; i++) begin
        o.pos[i] = t.pos[i][COORD_W-1:0];
        o.vel[i] = t.vel[i][COORD_W-1:0];
      end
      o.contact = 1'b0;
      return o;
    end
    if (d2 == 0) begin
      for (int i = 0; i < 3; i++) begin
        a = t.pos[i] - t.bmin[i];
        b = t.bmax[i] - t.pos[i];
        fd[i] = a < b ? a : b;
        nrm[i] = 0;
      end
      if (fd[0] <= fd[1] && fd[0] <= fd[2]) ax = 0;
      else if (fd[1] <= fd[2]) ax = 1;
      else ax = 2;
      nrm[ax] = (2 * t.pos[ax] < t.bmin[ax] + t.bmax[ax]) ? -one : one;
    end else begin
      d = int_sqrt(d2);
      for (int i = 0; i < 3; i++) begin
        q = (abs_l(dl[i]) << FRAC_BITS) / d;
        if (q > one) q = one;
        nrm[i] = dl[i] < 0 ? -q : q;
      end
    end
    vn = 0;
    for (int i = 0; i < 3; i++) begin
      o.pos[i] = COORD_W'(sat_coord(cl[i] + fx_mul(nrm[i], radius, FRAC_BITS)));
      vn += fx_mul(t.vel[i], nrm[i], FRAC_BITS);
    end
    for (int i = 0; i < 3; i++) o.vel[i] = t.vel[i][COORD_W-1:0];
    if (vn < 0) begin
      k = vn + fx_mul(vn, restitution, REST_FRAC);
      for (int i = 0; i < 3; i++)
        o.vel[i] = COORD_W'(sat_coord(t.vel[i] - fx_mul(k, nrm[i], FRAC_BITS)));
    end
    o.contact = 1'b1;
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // entered and left at a falling edge; valid stays high when the next call has no gap
  task automatic send_test(test_t t);
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.pos_x     <= COORD_W'(t.pos[0]);
    req.pos_y     <= COORD_W'(t.pos[1]);
    req.pos_z     <= COORD_W'(t.pos[2]);
    req.vel_x     <= COORD_W'(t.vel[0]);
    req.vel_y     <= COORD_W'(t.vel[1]);
    req.vel_z     <= COORD_W'(t.vel[2]);
    req.box_min_x <= COORD_W'(t.bmin[0]);
    req.box_min_y <= COORD_W'(t.bmin[1]);
    req.box_min_z <= COORD_W'(t.bmin[2]);
    req.box_max_x <= COORD_W'(t.bmax[0]);
    req.box_max_y <= COORD_W'(t.bmax[1]);
    req.box_max_z <= COORD_W'(t.bmax[2]);
    do @(posedge clk); while (!req.ready);
    pending_q.insert(pending_q.size(), resolve(t));
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    req.valid <= 1'b0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_q.size() != 0) begin
      $display("Verification failed");
      $finish;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, longint value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_RADIUS) radius = value & ((64'sd1 <<< RAD_W) - 1);
    else restitution = value & ((64'sd1 <<< REST_W) - 1);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic longint rnd32();
    return longint'(signed'($urandom()));
  endfunction

  function automatic longint near(longint v, longint spread);
    longint r;
    r = v + longint'($urandom_range(0, 32'(2 * spread))) - spread;
    return sat_coord(r);
  endfunction

  // a box around the origin region with a sphere close to one of its faces
  function automatic test_t close_test(longint reach);
    test_t t;
    longint lo, sz;
    for (int i = 0; i < 3; i++) begin
      lo = longint'($urandom_range(0, 20 << 16)) - (10 << 16);
      sz = $urandom_range(0, 4 << 16);
      t.bmin[i] = lo;
      t.bmax[i] = lo + sz;
      t.vel[i] = longint'($urandom_range(0, 8 << 16)) - (4 << 16);
      case ($urandom_range(0, 2))
        0: t.pos[i] = near(t.bmin[i], reach);
        1: t.pos[i] = near(t.bmax[i], reach);
        default: t.pos[i] = lo + $urandom_range(0, 32'(sz));
      endcase
    end
    if ($urandom_range(0, 9) == 0) t.vel[$urandom_range(0, 2)] = rnd32();
    return t;
  endfunction

  function automatic test_t noise_test();
    test_t t;
    for (int i = 0; i < 3; i++) begin
      t.pos[i] = rnd32();
      t.vel[i] = rnd32();
      t.bmin[i] = rnd32();
      t.bmax[i] = rnd32();
    end
    return t;
  endfunction

  function automatic test_t mk(longint px, longint py, longint pz, longint vx, longint vy,
                               longint vz, longint lo, longint hi);
    test_t t;
    t.pos = '{px, py, pz};
    t.vel = '{vx, vy, vz};
    for (int i = 0; i < 3; i++) begin
      t.bmin[i] = lo;
      t.bmax[i] = hi;
    end
    return t;
  endfunction

  task automatic test_directed();
    longint one, mx, mn;
    test_t  t;
    one = 64'sd1 <<< 16;
    mx = 64'sd2147483647;
    mn = -mx - 1;
    // separated, touching each face, and centre inside with ties
    send_test(mk(5 * one, 0, 0, 1, 2, 3, -one, one));
    send_test(mk(one + 100, 0, 0, -one, 0, 0, -one, one));
    send_test(mk(0, -one - 100, 0, 0, one, 0, -one, one));
    send_test(mk(0, 0, one + 4000, one, one, -one, -one, one));
    send_test(mk(0, 0, 0, one, one, one, -one, one));
    send_test(mk(-one / 2, 0, 0, one, 0, 0, -one, one));
    send_test(mk(one / 2, one / 2, 0, -one, -one, 0, -one, one));
    send_test(mk(one / 2, one / 2, one / 2, 0, 0, -one, -one, one));
    send_test(mk(one + 3000, one + 3000, one + 3000, -one, -one, -one, -one, one));
    // fields at their extremes
    send_test(mk(mx, mx, mx, mx, mx, mx, mx, mx));
    send_test(mk(mn, mn, mn, mn, mn, mn, mn, mn));
    send_test(mk(mx, mn, 0, mn, mx, -1, mn, mx));
    send_test(mk(mn + 1000, 0, 0, mx, mn, mx, mn, mx));
    // inverted box on an axis
    t = mk(0, 0, 0, -one, 0, 0, -one, one);
    t.bmin[0] = one;
    t.bmax[0] = -one;
    send_test(t);
    t.pos[0] = 2 * one;
    send_test(t);
    t.pos[0] = -2 * one;
    send_test(t);
    // saturation of velocity and position near the range edge
    send_test(mk(mx, 0, 0, mn, mn, 0, mx - one, mx - 10));
    send_test(mk(mn, 0, 0, mx, 0, 0, mn + 10, mn + one));
  endtask

  task automatic test_random(int count, longint reach);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) send_test(close_test(reach));
      else send_test(noise_test());
    end
  endtask

  // response side: random ready, compare every transfer with the oldest prediction
  initial begin
    int        g;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      g = long_stalls ? gap_len() : ($urandom_range(0, 3) == 0 ? gap_len() : 0);
      if (g > 0) begin
        rsp.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    resolved_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (e.contact) n_contacts++;
        if (rsp.new_pos_x !== e.pos[0] || rsp.new_pos_y !== e.pos[1] ||
            rsp.new_pos_z !== e.pos[2] || rsp.new_vel_x !== e.vel[0] ||
            rsp.new_vel_y !== e.vel[1] || rsp.new_vel_z !== e.vel[2] ||
            rsp.contact !== e.contact) begin
          $display("%0t: expected pos %h %h %h vel %h %h %h contact %b", $time,
                   e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2], e.contact);
          $display("%0t: actual   pos %h %h %h vel %h %h %h contact %b", $time,
                   rsp.new_pos_x, rsp.new_pos_y, rsp.new_pos_z, rsp.new_vel_x,
                   rsp.new_vel_y, rsp.new_vel_z, rsp.contact);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    {req.pos_x, req.pos_y, req.pos_z, req.vel_x, req.vel_y, req.vel_z} = '0;
    {req.box_min_x, req.box_min_y, req.box_min_z} = '0;
    {req.box_max_x, req.box_max_y, req.box_max_z} = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_RADIUS;
    cfg.data = '0;
    radius = RADIUS_RESET;
    restitution = REST_RESET;
    errors = 0;
    n_items = 0;
    n_contacts = 0;
    n_results = 0;
    long_stalls = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(120, 1 << 14);
    drain();
    write_reg(REG_RADIUS, 0);
    write_reg(REG_REST, 0);
    test_random(40, 1 << 15);
    drain();
    write_reg(REG_RADIUS, 1 << 24);
    write_reg(REG_REST, 1 << 16);
    long_stalls = 1'b1;
    test_random(100, 1 << 25);
    drain();
    write_reg(REG_RADIUS, (1 << 25) - 1);
    write_reg(REG_REST, (1 << 17) - 1);
    test_random(60, 1 << 25);
    drain();
    long_stalls = 1'b0;
    write_reg(REG_RADIUS, 3 << 15);
    write_reg(REG_REST, 40000);
    test_random(180, 1 << 16);
    drain();

    $display("run covered %0d tests, %0d with contact, over five register settings",
             n_items, n_contacts);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
